// File: hw/rtl/tpd_pkg.sv
package tpd_pkg;

  localparam int WINDOW      = 7;
  localparam int SAMPLE_BITS = 12;

  localparam int MID_COUNT    = WINDOW - 4;
  localparam int LO_RANK      = 2;
  localparam int HI_RANK      = WINDOW - 3;
  localparam int COUNT_BITS   = $clog2(WINDOW + 1);
  localparam int RANK_BITS    = $clog2(WINDOW);
  localparam int SUM_BITS     = SAMPLE_BITS + $clog2(MID_COUNT);
  localparam int TIME_BITS    = 24;
  localparam int STEP_BITS    = 16;
  localparam int COORD_BITS   = 12;
  localparam int LIMIT_BITS   = 12;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam int CMP_BITS     = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

  // floor(2^SUM_BITS / MID_COUNT); quotient estimate is at most one short
  localparam logic [SUM_BITS:0] DIV_RECIP = (SUM_BITS + 1)'((1 << SUM_BITS) / MID_COUNT);

  localparam logic [TIME_BITS-1:0]  TIME_MAX       = {TIME_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0]  DEBOUNCE_RESET = 24'd16000;
  localparam logic [TIME_BITS-1:0]  REPEAT_RESET   = 24'd50000;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET    = 12'd10;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_DEBOUNCE = 3'd1,
    MODE_SAMPLING = 3'd2,
    MODE_TOUCHED  = 3'd3,
    MODE_FROZEN   = 3'd4
  } pen_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DIV,
    ST_FIX
  } ctrl_state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT,
    OP_DIV
  } chain_op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_REPEAT   = 2'd1,
    CFG_LIMIT    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    chain_op_e             op;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_BITS-1:0]  rank;
  } chain_ctrl_t;

  typedef struct packed {
    logic    ok;
    sample_t mean;
  } chain_stat_t;

  typedef struct packed {
    logic                  new_point;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    pen_mode_e             pen_mode;
  } result_t;

endpackage

// File: hw/rtl/tpd_if.sv
interface tpd_poll_if import tpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  pen_down;
  logic [STEP_BITS-1:0]  time_step_us;
  logic [COORD_BITS-1:0] sample_x;
  logic [COORD_BITS-1:0] sample_y;

  modport source (output valid, pen_down, time_step_us, sample_x, sample_y, input ready);
  modport sink (input valid, pen_down, time_step_us, sample_x, sample_y, output ready);
endinterface

interface tpd_point_if import tpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  new_point;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic [2:0]            pen_mode;

  modport source (output valid, new_point, point_x, point_y, pen_mode, input ready);
  modport sink (input valid, new_point, point_x, point_y, pen_mode, output ready);
endinterface

// File: hw/rtl/tpd_cell.sv
module tpd_cell import tpd_pkg::*; (
  input  logic      clk_i,
  input  chain_op_e op_i,
  input  logic      valid_i,
  input  sample_t   sample_i,
  input  logic      take_prev_i,
  input  sample_t   val_prev_i,
  input  sample_t   val_next_i,
  output logic      take_o,
  output sample_t   val_o
);

  sample_t val_q, val_d;

  // empty cells and cells holding a larger value make room for the new item
  assign take_o = !valid_i || (val_q > sample_i);

  always_comb begin
    val_d = val_q;
    case (op_i)
      OP_INSERT: begin
        if (take_o) begin
          val_d = take_prev_i ? val_prev_i : sample_i;
        end
      end
      OP_SHIFT: val_d = val_next_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// File: hw/rtl/tpd_chain.sv
module tpd_chain import tpd_pkg::*; (
  input  logic                  clk_i,
  input  chain_ctrl_t           ctrl_i,
  input  sample_t               sample_i,
  input  logic [LIMIT_BITS-1:0] limit_i,
  output chain_stat_t           stat_o
);

  sample_t val  [WINDOW];
  logic    take [WINDOW];
  logic    valid[WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    sample_t val_prev, val_next;
    logic    take_prev;

    assign valid[i] = COUNT_BITS'(i) < ctrl_i.count;

    if (i == 0) begin : g_head
      assign take_prev = 1'b0;
      assign val_prev  = sample_i;
    end else begin : g_body
      assign take_prev = take[i-1];
      assign val_prev  = val[i-1];
    end

    if (i == WINDOW - 1) begin : g_tail
      assign val_next = val[i];
    end else begin : g_inner
      assign val_next = val[i+1];
    end

    tpd_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (ctrl_i.op),
      .valid_i    (valid[i]),
      .sample_i   (sample_i),
      .take_prev_i(take_prev),
      .val_prev_i (val_prev),
      .val_next_i (val_next),
      .take_o     (take[i]),
      .val_o      (val[i])
    );
  end

  logic [SUM_BITS-1:0]   acc_q, acc_d;
  logic [SUM_BITS-1:0]   q0_q, q0_d;
  sample_t               lo_q, lo_d, hi_q, hi_d;
  logic                  ok_q, ok_d;
  logic                  in_mid;
  logic [2*SUM_BITS:0]   prod;
  sample_t               spread;
  logic [SUM_BITS-1:0]   rem;
  logic [SUM_BITS-1:0]   mean_full;

  assign in_mid = (ctrl_i.rank >= RANK_BITS'(LO_RANK)) && (ctrl_i.rank <= RANK_BITS'(HI_RANK));
  assign prod   = (2*SUM_BITS+1)'(acc_q) * (2*SUM_BITS+1)'(DIV_RECIP);
  assign spread = hi_q - lo_q;

  always_comb begin
    acc_d = acc_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    q0_d  = q0_q;
    ok_d  = ok_q;
    case (ctrl_i.op)
      OP_SHIFT: begin
        // cell 0 presents rank ctrl_i.rank as the row drains toward it
        if (ctrl_i.rank == '0) begin
          acc_d = '0;
        end
        if (in_mid) begin
          acc_d = acc_q + SUM_BITS'(val[0]);
        end
        if (ctrl_i.rank == RANK_BITS'(LO_RANK)) begin
          lo_d = val[0];
        end
        if (ctrl_i.rank == RANK_BITS'(HI_RANK)) begin
          hi_d = val[0];
        end
      end
      OP_DIV: begin
        q0_d = prod[2*SUM_BITS-1:SUM_BITS];
        ok_d = CMP_BITS'(spread) < CMP_BITS'(limit_i);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    q0_q  <= q0_d;
    ok_q  <= ok_d;
  end

  // one correction step after the reciprocal estimate
  assign rem       = acc_q - SUM_BITS'(q0_q * SUM_BITS'(MID_COUNT));
  assign mean_full = (rem >= SUM_BITS'(MID_COUNT)) ? q0_q + 1'b1 : q0_q;

  assign stat_o.ok   = ok_q;
  assign stat_o.mean = SAMPLE_BITS'(mean_full);

endmodule

// File: hw/rtl/touch_pen_debounce_trimmed_mean.sv
// channel  | dir | handshake     | payload
// poll_i   | in  | valid / ready | pen_down, time_step_us, sample_x, sample_y
// point_o  | out | valid / ready | new_point, point_x, point_y, pen_mode
// cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// For most polls the result is registered and the next poll is taken in the
// following cycle unless the skid entry is full. A window-end poll is accepted,
// then ranks 0 through HI_RANK of the sorted cell row drain into the
// accumulator (ST_SHIFT), then come the reciprocal multiply (ST_DIV) and its
// correction (ST_FIX); ready stays low from ST_SHIFT through ST_FIX.
// Reset is asynchronous; it restores mode, timer, held point and registers.
// One skid entry behind the output register; ready drops while it is full.
module touch_pen_debounce_trimmed_mean import tpd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  tpd_poll_if.sink                 poll_i,
  tpd_point_if.source              point_o
);

  logic [TIME_BITS-1:0]  debounce_q, repeat_q;
  logic [LIMIT_BITS-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      repeat_q   <= REPEAT_RESET;
      limit_q    <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE: debounce_q <= cfg_data_i[TIME_BITS-1:0];
        CFG_REPEAT:   repeat_q   <= cfg_data_i[TIME_BITS-1:0];
        CFG_LIMIT:    limit_q    <= cfg_data_i[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  ctrl_state_e           state_q, state_d;
  pen_mode_e             mode_q, mode_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [RANK_BITS-1:0]  rank_q, rank_d;
  logic [TIME_BITS-1:0]  elapsed_q, elapsed_d;
  sample_t               held_x_q, held_x_d, held_y_q, held_y_d;
  result_t               out_q, out_d, skid_q, skid_d;
  logic                  out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic                  in_fire, out_space, res_valid, point;
  result_t               res;
  logic [TIME_BITS:0]    step_sum;
  logic [TIME_BITS-1:0]  elapsed_sat;
  chain_ctrl_t           ctrl;
  chain_stat_t           stat_x, stat_y;

  assign poll_i.ready = (state_q == ST_IDLE) && !skid_valid_q;
  assign in_fire      = poll_i.valid && poll_i.ready;
  assign out_space    = !out_valid_q || point_o.ready;

  assign step_sum    = {1'b0, elapsed_q} + (TIME_BITS+1)'(poll_i.time_step_us);
  assign elapsed_sat = step_sum[TIME_BITS] ? TIME_MAX : step_sum[TIME_BITS-1:0];

  tpd_chain u_chain_x (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .sample_i(SAMPLE_BITS'(poll_i.sample_x)),
    .limit_i (limit_q),
    .stat_o  (stat_x)
  );

  tpd_chain u_chain_y (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .sample_i(SAMPLE_BITS'(poll_i.sample_y)),
    .limit_i (limit_q),
    .stat_o  (stat_y)
  );

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    count_d    = count_q;
    rank_d     = rank_q;
    elapsed_d  = elapsed_q;
    held_x_d   = held_x_q;
    held_y_d   = held_y_q;
    ctrl.op    = OP_HOLD;
    ctrl.count = count_q;
    ctrl.rank  = rank_q;
    res_valid  = 1'b0;
    point      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          elapsed_d = elapsed_sat;
          res_valid = 1'b1;
          if (mode_q != MODE_IDLE && !poll_i.pen_down) begin
            count_d = '0;
            mode_d  = MODE_IDLE;
          end else begin
            case (mode_q)
              MODE_IDLE: begin
                if (poll_i.pen_down) begin
                  mode_d    = MODE_DEBOUNCE;
                  elapsed_d = '0;
                end
              end
              MODE_DEBOUNCE: begin
                if (elapsed_sat > debounce_q) begin
                  count_d = '0;
                  mode_d  = MODE_SAMPLING;
                end
              end
              MODE_SAMPLING, MODE_TOUCHED: begin
                if (count_q < COUNT_BITS'(WINDOW)) begin
                  ctrl.op = OP_INSERT;
                  count_d = count_q + 1'b1;
                end else begin
                  // extra sample is dropped; evaluate the full window
                  res_valid = 1'b0;
                  count_d   = '0;
                  rank_d    = '0;
                  state_d   = ST_SHIFT;
                  if (mode_q == MODE_SAMPLING) begin
                    elapsed_d = '0;
                  end
                end
              end
              MODE_FROZEN: begin
                if (elapsed_sat > repeat_q) begin
                  mode_d    = MODE_TOUCHED;
                  count_d   = '0;
                  elapsed_d = '0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_SHIFT: begin
        ctrl.op = OP_SHIFT;
        rank_d  = rank_q + 1'b1;
        if (rank_q == RANK_BITS'(HI_RANK)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        ctrl.op = OP_DIV;
        state_d = ST_FIX;
      end
      ST_FIX: begin
        res_valid = 1'b1;
        state_d   = ST_IDLE;
        if (stat_x.ok && stat_y.ok) begin
          point    = 1'b1;
          held_x_d = stat_x.mean;
          held_y_d = stat_y.mean;
          mode_d   = (mode_q == MODE_SAMPLING) ? MODE_TOUCHED : MODE_FROZEN;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    res.new_point = point;
    res.point_x   = COORD_BITS'(held_x_d);
    res.point_y   = COORD_BITS'(held_y_d);
    res.pen_mode  = mode_d;

    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_space) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_d       = res;
        skid_valid_d = res_valid;
      end else begin
        out_d       = res;
        out_valid_d = res_valid;
      end
    end else if (res_valid) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= MODE_IDLE;
      count_q      <= '0;
      rank_q       <= '0;
      elapsed_q    <= '0;
      held_x_q     <= '0;
      held_y_q     <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      count_q      <= count_d;
      rank_q       <= rank_d;
      elapsed_q    <= elapsed_d;
      held_x_q     <= held_x_d;
      held_y_q     <= held_y_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign point_o.valid     = out_valid_q;
  assign point_o.new_point = out_q.new_point;
  assign point_o.point_x   = out_q.point_x;
  assign point_o.point_y   = out_q.point_y;
  assign point_o.pen_mode  = out_q.pen_mode;

endmodule

// File: hw/rtl/tpd_checker.sv
module tpd_checker import tpd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  new_point_i,
  input logic [COORD_BITS-1:0] point_x_i,
  input logic [COORD_BITS-1:0] point_y_i,
  input logic [2:0]            pen_mode_i
);

  logic [COORD_BITS-1:0] last_x_q, last_y_q;
  logic                  out_fire;

  assign out_fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q <= '0;
      last_y_q <= '0;
    end else if (out_fire) begin
      last_x_q <= point_x_i;
      last_y_q <= point_y_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(point_x_i) && $stable(point_y_i)
      && $stable(new_point_i) && $stable(pen_mode_i))
    else $error("stalled result item changed");

  a_point_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && new_point_i |-> pen_mode_i == MODE_TOUCHED || pen_mode_i == MODE_FROZEN)
    else $error("new point reported outside touched or frozen");

  a_point_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !new_point_i |-> point_x_i == last_x_q && point_y_i == last_y_q)
    else $error("held point changed without a new point");

endmodule

bind touch_pen_debounce_trimmed_mean tpd_checker u_tpd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(point_o.valid),
  .out_ready_i(point_o.ready),
  .new_point_i(point_o.new_point),
  .point_x_i  (point_o.point_x),
  .point_y_i  (point_o.point_y),
  .pen_mode_i (point_o.pen_mode)
);

// File: dv/tpd_point_checker.sv
module tpd_point_checker import tpd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  tpd_poll_if                      poll,
  tpd_point_if                     point,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       checked_o,
  output int                       points_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the registers and of the pen controller
  logic [TIME_BITS-1:0]  debounce_us;
  logic [TIME_BITS-1:0]  repeat_us;
  logic [LIMIT_BITS-1:0] spread_max;

  pen_mode_e            mode_q;
  int unsigned          fill;
  sample_t              x_hist [WINDOW];
  sample_t              y_hist [WINDOW];
  logic [TIME_BITS-1:0] timer_us;
  sample_t              last_x;
  sample_t              last_y;

  result_t expected_points [$];

  // sort the window, gate on the spread of the middle ranks, average them
  function automatic bit middle_mean(input sample_t v [WINDOW], output sample_t mean);
    sample_t     s [WINDOW];
    sample_t     t;
    int unsigned total;
    s = v;
    mean = '0;
    for (int i = 0; i < WINDOW - 1; i++) begin
      for (int j = 0; j < WINDOW - 1 - i; j++) begin
        if (s[j] > s[j+1]) begin
          t = s[j];
          s[j] = s[j+1];
          s[j+1] = t;
        end
      end
    end
    if (int'(s[HI_RANK]) - int'(s[LO_RANK]) >= int'(spread_max)) return 1'b0;
    total = 0;
    for (int i = LO_RANK; i <= HI_RANK; i++) total += s[i];
    mean = sample_t'(total / MID_COUNT);
    return 1'b1;
  endfunction

  function automatic result_t predict_point(input logic pen,
                                            input logic [STEP_BITS-1:0] step,
                                            input sample_t sx, input sample_t sy);
    result_t            r;
    logic [TIME_BITS:0] sum;
    bit                 hit;
    bit                 closed;
    sample_t            mx;
    sample_t            my;
    hit = 1'b0;
    closed = 1'b0;
    sum = {1'b0, timer_us} + (TIME_BITS+1)'(step);
    timer_us = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_BITS-1:0];

    if (mode_q == MODE_IDLE) begin
      if (pen) begin
        mode_q = MODE_DEBOUNCE;
        timer_us = '0;
      end
    end else if (!pen) begin
      fill = 0;
      mode_q = MODE_IDLE;
    end else begin
      case (mode_q)
        MODE_DEBOUNCE: begin
          if (timer_us > debounce_us) begin
            fill = 0;
            mode_q = MODE_SAMPLING;
          end
        end
        MODE_SAMPLING, MODE_TOUCHED: begin
          if (fill < WINDOW) begin
            x_hist[fill] = sx;
            y_hist[fill] = sy;
            fill++;
          end else begin
            // extra sample closes the window and is dropped
            closed = 1'b1;
            fill = 0;
            if (middle_mean(x_hist, mx)) begin
              if (middle_mean(y_hist, my)) begin
                hit = 1'b1;
                last_x = mx;
                last_y = my;
              end
            end
          end
          if (closed && mode_q == MODE_SAMPLING) timer_us = '0;
          if (hit) begin
            if (mode_q == MODE_SAMPLING) mode_q = MODE_TOUCHED;
            else mode_q = MODE_FROZEN;
          end
        end
        MODE_FROZEN: begin
          if (timer_us > repeat_us) begin
            mode_q = MODE_TOUCHED;
            fill = 0;
            timer_us = '0;
          end
        end
        default: ;
      endcase
    end

    r.new_point = hit;
    r.point_x   = last_x;
    r.point_y   = last_y;
    r.pen_mode  = mode_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      debounce_us  = DEBOUNCE_RESET;
      repeat_us    = REPEAT_RESET;
      spread_max   = LIMIT_RESET;
      mode_q       = MODE_IDLE;
      fill         = 0;
      timer_us     = '0;
      last_x       = '0;
      last_y       = '0;
      expected_points.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      points_o     = 0;
    end else begin
      // a result is registered before it leaves, never in its poll's own cycle, so check first
      if (point.valid && point.ready) begin
        checked_o++;
        if (point.new_point) points_o++;
        if (expected_points.size() == 0) begin
          $error("result with no poll waiting: new_point %0d x %0d y %0d mode %0d",
                 point.new_point, point.point_x, point.point_y, point.pen_mode);
          fail_count_o++;
        end else begin
          want = expected_points.pop_front();
          if (point.new_point !== want.new_point) begin
            $error("new_point: expected %0d, actual %0d", want.new_point, point.new_point);
            fail_count_o++;
          end
          if (point.point_x !== want.point_x) begin
            $error("point_x: expected %0d, actual %0d", want.point_x, point.point_x);
            fail_count_o++;
          end
          if (point.point_y !== want.point_y) begin
            $error("point_y: expected %0d, actual %0d", want.point_y, point.point_y);
            fail_count_o++;
          end
          if (point.pen_mode !== 3'(want.pen_mode)) begin
            $error("pen_mode: expected %0d, actual %0d", want.pen_mode, point.pen_mode);
            fail_count_o++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE: debounce_us = cfg_data_i;
          CFG_REPEAT:   repeat_us = cfg_data_i;
          CFG_LIMIT:    spread_max = cfg_data_i[LIMIT_BITS-1:0];
          default: ;
        endcase
      end

      if (poll.valid && poll.ready) begin
        expected_points.push_back(predict_point(poll.pen_down, poll.time_step_us,
                                                poll.sample_x, poll.sample_y));
      end
      pending_o = expected_points.size();
    end
  end

endmodule

// File: dv/tb_touch_pen_debounce_trimmed_mean.sv
module tb_touch_pen_debounce_trimmed_mean import tpd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 80;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  tpd_poll_if  poll_ch ();
  tpd_point_if point_ch ();

  int fail_count;
  int pending;
  int checked;
  int points;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int polls_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  touch_pen_debounce_trimmed_mean dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .poll_i     (poll_ch),
    .point_o    (point_ch)
  );

  tpd_point_checker u_point_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .poll         (poll_ch),
    .point        (point_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .points_o     (points)
  );

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    point_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_token != hold_seen) begin
        point_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_seen = hold_token;
      end
      point_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL touch_pen_debounce_trimmed_mean");
    $finish;
  end

  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input int unsigned deb_us, input int unsigned hold_us,
                            input int unsigned lim);
    write_cfg(CFG_DEBOUNCE, CFG_DATA_BITS'(deb_us));
    write_cfg(CFG_REPEAT, CFG_DATA_BITS'(hold_us));
    write_cfg(CFG_LIMIT, CFG_DATA_BITS'(lim));
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_poll(input logic pen, input logic [STEP_BITS-1:0] step,
                           input sample_t x, input sample_t y);
    while ($urandom_range(99) < send_idle_pct) begin
      poll_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    poll_ch.valid        = 1'b1;
    poll_ch.pen_down     = pen;
    poll_ch.time_step_us = step;
    poll_ch.sample_x     = x;
    poll_ch.sample_y     = y;
    do @(posedge clk_i); while (!poll_ch.ready);
    @(negedge clk_i);
    polls_sent++;
  endtask

  // sender pauses until every result is back, then lets the block settle
  task automatic quiesce();
    poll_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (WINDOW + 12) @(negedge clk_i);
  endtask

  function automatic logic [STEP_BITS-1:0] pick_step();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '1;
    if (r == 1) return '0;
    if (r < 5) return STEP_BITS'($urandom);
    return STEP_BITS'($urandom_range(6000));
  endfunction

  // jittered sample around a center, with the odd outlier
  function automatic sample_t near(input int c, input int jit);
    int v;
    v = c + int'($urandom_range(2 * jit)) - jit;
    if ($urandom_range(15) == 0) v = int'($urandom_range(4095));
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return sample_t'(v);
  endfunction

  task automatic touch_gesture(input int jit_max);
    int cx;
    int cy;
    int jit;
    cx = int'($urandom_range(4095));
    cy = int'($urandom_range(4095));
    jit = int'($urandom_range(jit_max));
    repeat ($urandom_range(3))
      send_poll(1'b0, STEP_BITS'($urandom), sample_t'($urandom), sample_t'($urandom));
    repeat ($urandom_range(1, 45))
      send_poll(1'b1, pick_step(), near(cx, jit), near(cy, jit));
  endtask

  task automatic run_phase(input int items, input int jit_max);
    int start;
    start = polls_sent;
    while (polls_sent - start < items) begin
      if ($urandom_range(6) == 0) begin
        repeat ($urandom_range(1, 8))
          send_poll(1'($urandom), STEP_BITS'($urandom), sample_t'($urandom),
                    sample_t'($urandom));
      end else begin
        touch_gesture(jit_max);
      end
    end
  endtask

  initial begin
    poll_ch.valid        = 1'b0;
    poll_ch.pen_down     = 1'b0;
    poll_ch.time_step_us = '0;
    poll_ch.sample_x     = '0;
    poll_ch.sample_y     = '0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_DEBOUNCE;
    cfg_data = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // out-of-range register index must leave the reset values alone
    write_cfg(CFG_UNUSED, CFG_DATA_BITS'($urandom));

    // directed: release from debounce, full-scale window, touched to frozen,
    // repeat timeout back to touched, release from touched
    send_poll(1'b0, '1, 12'hFFF, 12'h000);
    send_poll(1'b1, '0, '0, '0);
    send_poll(1'b0, '0, '0, '0);
    send_poll(1'b1, '0, '0, '0);
    send_poll(1'b1, '1, '0, '0);
    repeat (WINDOW) send_poll(1'b1, '0, 12'hFFF, 12'h000);
    send_poll(1'b1, '0, 12'h000, 12'hFFF);
    for (int i = 0; i <= WINDOW; i++)
      send_poll(1'b1, STEP_BITS'(100), sample_t'(2048 + i % 3), sample_t'(1024 - i % 2));
    send_poll(1'b1, '1, 12'hABC, 12'h543);
    send_poll(1'b0, STEP_BITS'(1), 12'h555, 12'hAAA);
    quiesce();

    // no idling, loosest gate
    set_config(0, 0, 4095);
    run_phase(320, 40);
    quiesce();

    send_idle_pct = 51;
    set_config(5000, 30000, 10);
    run_phase(320, 5);
    quiesce();

    send_idle_pct = 0;
    recv_stall_pct = 51;
    set_config(20000, 40000, 3);
    hold_token++;
    run_phase(320, 2);
    quiesce();

    send_idle_pct = 31;
    recv_stall_pct = 31;
    set_config(1000, 8000, 64);
    run_phase(320, 40);
    quiesce();

    // timer runs into saturation while debouncing; frozen never times out
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(TIME_MAX - 1, TIME_MAX, 4095);
    repeat (290) send_poll(1'b1, '1, near(1500, 20), near(2500, 20));
    send_poll(1'b0, '1, '0, '0);
    quiesce();

    // zero limit rejects every window
    send_idle_pct = 31;
    recv_stall_pct = 31;
    set_config(0, 12345, 0);
    run_phase(80, 3);
    quiesce();

    $display("Run: %0d polls over gap-free, sender-gap, receiver-stall and mixed phases,",
             polls_sent);
    $display("  %0d results compared, %0d touch points, register extremes and timer saturation",
             checked, points);
    if (fail_count == 0) begin
      $display("PASS touch_pen_debounce_trimmed_mean");
    end else begin
      $display("FAIL touch_pen_debounce_trimmed_mean");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_if.sv
hw/rtl/tpd_cell.sv
hw/rtl/tpd_chain.sv
hw/rtl/touch_pen_debounce_trimmed_mean.sv
hw/rtl/tpd_checker.sv
dv/tpd_point_checker.sv
dv/tb_touch_pen_debounce_trimmed_mean.sv
